// ===== rtl/lfr_pkg.sv =====
`timescale 1ns / 1ps
package lfr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int MAX_LINKS     = 32;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 144;
    localparam int ADDR_W     = 4;

    localparam logic [ADDR_W-1:0] REG_NODE_ADDRESS = 4'h0;
    localparam logic [ADDR_W-1:0] REG_LINK_COUNT   = 4'h4;
    localparam logic [ADDR_W-1:0] REG_MAX_HOPS     = 4'h8;

    localparam logic [2:0] ACT_DROP     = 3'd0;
    localparam logic [2:0] ACT_DELIVER  = 3'd1;
    localparam logic [2:0] ACT_TRANSMIT = 3'd2;
    localparam logic [2:0] ACT_ACKED    = 3'd3;
    localparam logic [2:0] ACT_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RES,
        S_LEARN,
        S_EMIT,
        S_EMIT2,
        S_DROP,
        S_FULL
    } t_state;

    typedef struct packed {
        logic cap;
        logic look;
        logic resolve;
        logic learn;
        logic emit;
        logic emit2;
        logic flag;
        logic [2:0] flag_act;
    } t_cmd;

    typedef struct packed {
        logic req;
        logic local_dst;
        logic hl_low;
        logic phase;
        logic full;
        logic two;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/lfr_ctrl.sv =====
`timescale 1ns / 1ps
module lfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lfr_pkg::t_status  i_st,
    output logic              o_in_ready,
    output lfr_pkg::t_cmd     o_cmd
);

    lfr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lfr_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfr_pkg::S_IDLE:  if (i_in_valid) n_state = lfr_pkg::S_LOOK;
            lfr_pkg::S_LOOK: begin
                if (i_st.req && !i_st.local_dst && i_st.hl_low && !i_st.phase)
                    n_state = lfr_pkg::S_DROP;
                else
                    n_state = lfr_pkg::S_RES;
            end
            lfr_pkg::S_RES: begin
                if (i_st.full)
                    n_state = lfr_pkg::S_FULL;
                else if (i_st.req && !i_st.local_dst && !i_st.phase)
                    n_state = lfr_pkg::S_LEARN;
                else
                    n_state = lfr_pkg::S_EMIT;
            end
            lfr_pkg::S_LEARN: n_state = lfr_pkg::S_LOOK;
            lfr_pkg::S_EMIT: begin
                if (i_st.out_free)
                    n_state = i_st.two ? lfr_pkg::S_EMIT2 : lfr_pkg::S_IDLE;
            end
            lfr_pkg::S_EMIT2, lfr_pkg::S_DROP, lfr_pkg::S_FULL: begin
                if (i_st.out_free) n_state = lfr_pkg::S_IDLE;
            end
            default: n_state = lfr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lfr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            lfr_pkg::S_LOOK: o_cmd.look = 1'b1;
            lfr_pkg::S_RES:  o_cmd.resolve = !i_st.full;
            lfr_pkg::S_LEARN: o_cmd.learn = 1'b1;
            lfr_pkg::S_EMIT:  o_cmd.emit = i_st.out_free;
            lfr_pkg::S_EMIT2: o_cmd.emit2 = i_st.out_free;
            lfr_pkg::S_DROP: begin
                o_cmd.flag     = i_st.out_free;
                o_cmd.flag_act = lfr_pkg::ACT_DROP;
            end
            lfr_pkg::S_FULL: begin
                o_cmd.flag     = i_st.out_free;
                o_cmd.flag_act = lfr_pkg::ACT_FULL;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/lfr_dp.sv =====
`timescale 1ns / 1ps
module lfr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lfr_pkg::t_cmd                     i_cmd,
    output lfr_pkg::t_status                  o_st,
    input  logic [15:0]                       i_node_address,
    input  logic [5:0]                        i_link_count,
    input  logic [3:0]                        i_max_hops,
    input  logic                              i_in_user,
    input  logic [lfr_pkg::IN_DATA_W-1:0]     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lfr_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic [2:0]                        o_out_user,
    output logic                              o_out_last
);

    // captured item
    logic        r_req, r_kind;
    logic [47:0] r_now, r_ts;
    logic [15:0] r_src, r_dest, r_seq;
    logic [3:0]  r_hl, r_ht;
    logic [5:0]  r_link;
    logic        r_phase;

    // peer table
    logic [15:0] r_peer [lfr_pkg::TABLE_ENTRIES];
    logic [15:0] r_nss  [lfr_pkg::TABLE_ENTRIES];
    logic [15:0] r_eds  [lfr_pkg::TABLE_ENTRIES];
    logic [15:0] r_eas  [lfr_pkg::TABLE_ENTRIES];
    logic [3:0]  r_lh   [lfr_pkg::TABLE_ENTRIES];
    logic [5:0]  r_bl   [lfr_pkg::TABLE_ENTRIES];
    logic [lfr_pkg::CNT_W-1:0] r_count;
    logic                      r_hit;
    logic [lfr_pkg::IDX_W-1:0] r_idx;

    // result register
    logic        r_ov, r_olast;
    logic [2:0]  r_oact;
    logic [lfr_pkg::OUT_DATA_W-1:0] r_odata;

    logic [15:0] key;
    logic        hit;
    logic [lfr_pkg::IDX_W-1:0] hit_idx;
    logic        is_full, data_ok, ack_ok, local_dst;
    logic [3:0]  nhl, nht;
    logic [3:0]  e_lh;
    logic [5:0]  e_bl;
    logic [15:0] e_nss, e_eds, e_eas;
    logic [31:0] all_mask, route_mask, excl_mask;
    logic [lfr_pkg::IDX_W-1:0] ins_idx;

    assign ins_idx   = r_count[lfr_pkg::IDX_W-1:0];
    assign local_dst = (r_dest == i_node_address);
    assign key       = (!r_req || r_phase) ? r_dest : r_src;
    assign nhl       = r_hl - 4'd1;
    assign nht       = (r_ht == 4'hF) ? 4'hF : r_ht + 4'd1;
    assign is_full   = !r_hit &&
                       (r_count == lfr_pkg::CNT_W'(lfr_pkg::TABLE_ENTRIES));

    assign e_lh  = r_lh[r_idx];
    assign e_bl  = r_bl[r_idx];
    assign e_nss = r_nss[r_idx];
    assign e_eds = r_eds[r_idx];
    assign e_eas = r_eas[r_idx];
    assign data_ok = !r_kind && (r_seq == e_eds);
    assign ack_ok  = r_kind && (r_seq == e_eas);

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int t = lfr_pkg::TABLE_ENTRIES - 1; t >= 0; t--) begin
            if ((lfr_pkg::CNT_W'(t) < r_count) && (r_peer[t] == key)) begin
                hit     = 1'b1;
                hit_idx = lfr_pkg::IDX_W'(t);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < lfr_pkg::MAX_LINKS; i++) begin
            all_mask[i]   = (7'(i) < 7'(i_link_count));
            route_mask[i] = (e_bl == 6'd0) ? all_mask[i]
                            : (all_mask[i] && (7'(e_bl) == 7'(i + 1)));
            excl_mask[i]  = route_mask[i] && (7'(r_link) != 7'(i + 1));
        end
    end

    assign o_st.req       = r_req;
    assign o_st.local_dst = local_dst;
    assign o_st.hl_low    = (r_hl <= 4'd1);
    assign o_st.phase     = r_phase;
    assign o_st.full      = is_full;
    assign o_st.two       = r_req && local_dst && data_ok;
    assign o_st.out_free  = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req   <= i_in_user;
            r_now   <= i_in_data[47:0];
            r_src   <= i_in_data[63:48];
            r_dest  <= i_in_data[79:64];
            r_kind  <= i_in_data[80];
            r_seq   <= i_in_data[96:81];
            r_hl    <= i_in_data[100:97];
            r_ht    <= i_in_data[104:101];
            r_ts    <= i_in_data[152:105];
            r_link  <= i_in_data[158:153];
            r_phase <= 1'b0;
        end else if (i_cmd.learn) begin
            r_phase <= 1'b1;
        end
        if (i_cmd.look) begin
            r_hit <= hit;
            r_idx <= hit_idx;
        end else if (i_cmd.resolve && !r_hit) begin
            r_idx <= ins_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.resolve && !r_hit) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && !r_hit) begin
            r_peer[ins_idx] <= key;
            r_nss[ins_idx]  <= '0;
            r_eds[ins_idx]  <= '0;
            r_eas[ins_idx]  <= '0;
            r_lh[ins_idx]   <= i_max_hops;
            r_bl[ins_idx]   <= '0;
        end else if (i_cmd.learn) begin
            if (e_lh >= nht) begin
                r_lh[r_idx] <= nht;
                r_bl[r_idx] <= r_link;
            end
        end else if (i_cmd.emit) begin
            if (!r_req) begin
                r_nss[r_idx] <= e_nss + 16'd1;
            end else if (local_dst && (data_ok || ack_ok)) begin
                if (data_ok) r_eds[r_idx] <= r_seq + 16'd1;
                else         r_eas[r_idx] <= r_seq + 16'd1;
                if (e_lh >= r_ht) begin
                    r_lh[r_idx] <= r_ht;
                    r_bl[r_idx] <= r_link;
                end
            end
        end
    end

    // result register: mask | src | dest | kind | seq | hl | ht | ts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit2 || i_cmd.flag) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.flag) begin
            r_oact  <= i_cmd.flag_act;
            r_olast <= 1'b1;
            r_odata <= '0;
        end else if (i_cmd.emit2) begin
            r_oact  <= lfr_pkg::ACT_TRANSMIT;
            r_olast <= 1'b1;
            r_odata <= {7'd0, r_ts, 4'd1, e_lh, r_seq, 1'b1, r_src,
                        i_node_address, route_mask};
        end else if (i_cmd.emit) begin
            r_olast <= 1'b1;
            if (!r_req) begin
                r_oact  <= lfr_pkg::ACT_TRANSMIT;
                r_odata <= {7'd0, r_now, 4'd1, e_lh, e_nss, 1'b0, r_dest,
                            i_node_address, route_mask};
            end else if (local_dst) begin
                if (data_ok || ack_ok) begin
                    r_oact  <= data_ok ? lfr_pkg::ACT_DELIVER : lfr_pkg::ACT_ACKED;
                    r_olast <= !data_ok;
                    r_odata <= {7'd0, r_ts, r_ht, r_hl, r_seq, r_kind, r_dest,
                                r_src, 32'd0};
                end else begin
                    r_oact  <= lfr_pkg::ACT_DROP;
                    r_odata <= '0;
                end
            end else begin
                r_oact  <= lfr_pkg::ACT_TRANSMIT;
                r_odata <= {7'd0, r_ts, nht, nhl, r_seq, r_kind, r_dest,
                            r_src, excl_mask};
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_odata;
    assign o_out_user  = r_oact;
    assign o_out_last  = r_olast;

endmodule

// ===== rtl/learning_flood_router.sv =====
`timescale 1ns / 1ps
// Flooding router node with a learned peer table (16 peers).
// Input stream (s_axis): one item per packet event. tuser selects a local
// send (0) or a packet arrived from a link (1); tdata carries the header.
// Output stream (m_axis): one or two result items per input item; tuser is
// the action code, tlast marks the final result of that input item.
// APB port: node_address at 0x0, link_count at 0x4, max_hops at 0x8;
// pready is always high, writes land on the access cycle.
// Flow: an item is taken in the idle state, then the key is compared against
// all peers in parallel, then resolved or inserted; transit packets repeat
// both for the destination after a learn step. The first result is then
// written to the output register (a transit packet with a spent hop limit
// is dropped right after the compare); a second result is emitted from its
// own state. One item is processed at a time, set by the controller walking
// the single table port.
// Reset: entry count cleared (table empty), registers to 0 / 1 / 4, output
// empty. When the receiver stalls, the result stays in the output register
// and the controller holds until it is taken; s_axis_tready stays low
// meanwhile.
module learning_flood_router (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_usec, in_src, in_dest, in_kind, in_seq, in_hops_left,
    // in_hops_taken, in_time_sent, arrived_link, pad (lowest first)
    input  logic [159:0] s_axis_tdata,
    // req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // link_mask, out_src, out_dest, out_kind, out_seq, out_hops_left,
    // out_hops_taken, out_time_sent, pad (lowest first)
    output logic [143:0] m_axis_tdata,
    // action
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] r_node_address;
    logic [5:0]  r_link_count;
    logic [3:0]  r_max_hops;
    logic        wr_en;

    lfr_pkg::t_cmd    cmd;
    lfr_pkg::t_status st;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= 16'd0;
            r_link_count   <= 6'd1;
            r_max_hops     <= 4'd4;
        end else if (wr_en) begin
            unique case (paddr)
                lfr_pkg::REG_NODE_ADDRESS: r_node_address <= pwdata[15:0];
                lfr_pkg::REG_LINK_COUNT:   r_link_count   <= pwdata[5:0];
                lfr_pkg::REG_MAX_HOPS:     r_max_hops     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            lfr_pkg::REG_NODE_ADDRESS: prdata = {16'd0, r_node_address};
            lfr_pkg::REG_LINK_COUNT:   prdata = {26'd0, r_link_count};
            lfr_pkg::REG_MAX_HOPS:     prdata = {28'd0, r_max_hops};
            default:                   prdata = 32'd0;
        endcase
    end

    lfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_st       (st),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    lfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_node_address (r_node_address),
        .i_link_count   (r_link_count),
        .i_max_hops     (r_max_hops),
        .i_in_user      (s_axis_tuser),
        .i_in_data      (s_axis_tdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata),
        .o_out_user     (m_axis_tuser),
        .o_out_last     (m_axis_tlast)
    );

endmodule
